// ===== rtl/selq_pkg.sv =====
// package with sizes, status codes and the beat types of the shared/exclusive lock queue
package selq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_WIDTH   = 8;

  localparam int PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W  = TAG_WIDTH + 1;
  localparam int HOLDER_W = 8;
  localparam int STATUS_W = 3;

  localparam logic [HOLDER_W-1:0] HOLDER_MAX = {HOLDER_W{1'b1}};
  localparam logic [PTR_W-1:0]    PTR_LAST   = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0]   FILL_FULL  = FILL_W'(QUEUE_DEPTH);

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED  = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_FULL     = 3'd2,
    ST_UNLOCKED = 3'd3,
    ST_IGNORED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_HEAD = 2'b10
  } state_t;

  typedef struct packed {
    status_t                status;
    logic                   grant_valid;
    logic [TAG_WIDTH-1:0]   grant_tag;
    logic                   grant_exclusive;
    logic [HOLDER_W-1:0]    holders;
    logic [FILL_W-1:0]      waiting;
  } result_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_LAST) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/shared_exclusive_lock_queue.sv =====
// top level: shared/exclusive lock manager with a fifo wait queue held in a synchronous ram
//
// input channel: in_func (0 lock, 1 unlock), in_want_exclusive, in_requester_tag.
// a beat moves when in_valid is high and in_stall is low.
// result channel: one result beat per input beat, in order, with status, grant
// fields and the holder and waiting counts after the step; out_valid/out_stall.
// for a lock request, or an unlock that finds nothing held or an empty queue,
// the result is registered at the accept edge and shows the next cycle.
// an unlock with queued waiters first has the queue head registered out of the
// ram, then in state S_HEAD its result is registered once the output is free.
// sustained rate: one beat per cycle while out_stall is low; an unlock that
// tries the queue head holds off new beats until it leaves S_HEAD.
// while a result is held by out_stall, no new beat is accepted and the head
// read waits; the result register holds its value.
// reset clears the counters, queue pointers and the result valid flag; the
// queue ram is not cleared, an entry is only read after it has been written.
module shared_exclusive_lock_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_func,
  input  logic                              in_want_exclusive,
  input  logic [selq_pkg::TAG_WIDTH-1:0]    in_requester_tag,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [selq_pkg::STATUS_W-1:0]     out_status,
  output logic                              out_grant_valid,
  output logic [selq_pkg::TAG_WIDTH-1:0]    out_grant_tag,
  output logic                              out_grant_exclusive,
  output logic [selq_pkg::HOLDER_W-1:0]     out_holders,
  output logic [selq_pkg::FILL_W-1:0]       out_waiting
);

  selq_pkg::state_t                    state_r, state_nxt;
  logic [selq_pkg::HOLDER_W-1:0]       holders_r, holders_nxt;
  logic                                held_excl_r, held_excl_nxt;
  logic [selq_pkg::PTR_W-1:0]          head_r, head_nxt;
  logic [selq_pkg::PTR_W-1:0]          tail_r, tail_nxt;
  logic [selq_pkg::FILL_W-1:0]         fill_r, fill_nxt;
  logic                                out_valid_r, out_valid_nxt;
  selq_pkg::result_t                   res_r, res_nxt;

  logic [selq_pkg::ENTRY_W-1:0]        wait_mem [selq_pkg::QUEUE_DEPTH];
  logic [selq_pkg::ENTRY_W-1:0]        rd_data_r;
  logic                                wr_en;
  logic [selq_pkg::ENTRY_W-1:0]        wr_data;

  logic                                out_free;
  logic                                in_fire;
  logic                                lock_ok;
  logic                                head_excl;
  logic [selq_pkg::TAG_WIDTH-1:0]      head_tag;
  logic [selq_pkg::HOLDER_W-1:0]       holders_dec;
  logic                                head_ok;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != selq_pkg::S_IDLE) || !out_free;
  assign in_fire   = in_valid && !in_stall;

  assign head_excl   = rd_data_r[selq_pkg::TAG_WIDTH];
  assign head_tag    = rd_data_r[selq_pkg::TAG_WIDTH-1:0];
  assign holders_dec = holders_r - selq_pkg::HOLDER_W'(1);

  // grant rule: free lock, or shared holders joined by a shared request below the cap
  assign lock_ok = (holders_r == '0) ||
                   (!held_excl_r && !in_want_exclusive && holders_r != selq_pkg::HOLDER_MAX);
  // after the decrement the count is below the cap
  assign head_ok = (holders_dec == '0) || (!held_excl_r && !head_excl);

  always_comb begin
    state_nxt     = state_r;
    holders_nxt   = holders_r;
    held_excl_nxt = held_excl_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && out_stall;
    res_nxt       = res_r;
    wr_en         = 1'b0;
    wr_data       = {in_want_exclusive, in_requester_tag};

    case (state_r)
      selq_pkg::S_IDLE: begin
        if (in_fire) begin
          res_nxt.grant_valid     = 1'b0;
          res_nxt.grant_tag       = '0;
          res_nxt.grant_exclusive = 1'b0;
          if (!in_func) begin
            if (lock_ok) begin
              holders_nxt             = holders_r + selq_pkg::HOLDER_W'(1);
              held_excl_nxt           = in_want_exclusive;
              res_nxt.status          = selq_pkg::ST_GRANTED;
              res_nxt.grant_valid     = 1'b1;
              res_nxt.grant_tag       = in_requester_tag;
              res_nxt.grant_exclusive = in_want_exclusive;
            end else if (fill_r == selq_pkg::FILL_FULL) begin
              res_nxt.status = selq_pkg::ST_FULL;
            end else begin
              wr_en          = 1'b1;
              tail_nxt       = selq_pkg::ptr_inc(tail_r);
              fill_nxt       = fill_r + selq_pkg::FILL_W'(1);
              res_nxt.status = selq_pkg::ST_QUEUED;
            end
            out_valid_nxt = 1'b1;
          end else if (holders_r == '0) begin
            res_nxt.status = selq_pkg::ST_IGNORED;
            out_valid_nxt  = 1'b1;
          end else if (fill_r == '0) begin
            holders_nxt    = holders_dec;
            res_nxt.status = selq_pkg::ST_UNLOCKED;
            out_valid_nxt  = 1'b1;
          end else begin
            // head entry comes out of the ram next cycle
            state_nxt = selq_pkg::S_HEAD;
          end
          res_nxt.holders = holders_nxt;
          res_nxt.waiting = fill_nxt;
        end
      end
      selq_pkg::S_HEAD: begin
        if (out_free) begin
          res_nxt.status = selq_pkg::ST_UNLOCKED;
          if (head_ok) begin
            holders_nxt             = holders_r;
            held_excl_nxt           = head_excl;
            head_nxt                = selq_pkg::ptr_inc(head_r);
            fill_nxt                = fill_r - selq_pkg::FILL_W'(1);
            res_nxt.grant_valid     = 1'b1;
            res_nxt.grant_tag       = head_tag;
            res_nxt.grant_exclusive = head_excl;
          end else begin
            holders_nxt = holders_dec;
          end
          res_nxt.holders = holders_nxt;
          res_nxt.waiting = fill_nxt;
          out_valid_nxt   = 1'b1;
          state_nxt       = selq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = selq_pkg::S_IDLE;
      end
    endcase
  end

  // wait queue ram: one write port at the tail, registered read at the head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      wait_mem[tail_r] <= wr_data;
    end
    rd_data_r <= wait_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= selq_pkg::S_IDLE;
      holders_r   <= '0;
      held_excl_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      holders_r   <= holders_nxt;
      held_excl_r <= held_excl_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = res_r.status;
  assign out_grant_valid     = res_r.grant_valid;
  assign out_grant_tag       = res_r.grant_tag;
  assign out_grant_exclusive = res_r.grant_exclusive;
  assign out_holders         = res_r.holders;
  assign out_waiting         = res_r.waiting;

endmodule

// ===== dv/tb_top.sv =====
// testbench for the shared/exclusive lock queue: directed and random lock traffic against a predictor
`timescale 1ns / 1ps

module tb_top;

  localparam logic FUNC_LOCK   = 1'b0;
  localparam logic FUNC_UNLOCK = 1'b1;
  localparam int   CLK_HALF    = 10;

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  logic                                in_func;
  logic                                in_want_exclusive;
  logic [selq_pkg::TAG_WIDTH-1:0]      in_requester_tag;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [selq_pkg::STATUS_W-1:0]       out_status;
  logic                                out_grant_valid;
  logic [selq_pkg::TAG_WIDTH-1:0]      out_grant_tag;
  logic                                out_grant_exclusive;
  logic [selq_pkg::HOLDER_W-1:0]       out_holders;
  logic [selq_pkg::FILL_W-1:0]         out_waiting;

  // lock state as the predictor sees it
  logic [selq_pkg::HOLDER_W-1:0]       holders_now = '0;
  logic                                held_excl = 1'b0;
  logic [selq_pkg::ENTRY_W-1:0]        waiters [selq_pkg::QUEUE_DEPTH];
  logic [selq_pkg::PTR_W-1:0]          wq_head = '0;
  logic [selq_pkg::PTR_W-1:0]          wq_tail = '0;
  logic [selq_pkg::FILL_W-1:0]         wq_fill = '0;

  selq_pkg::result_t                   pending_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int beats_sent = 0;
  int results_checked = 0;
  int grants_seen = 0;
  int queued_seen = 0;
  int refused_seen = 0;
  int ignored_seen = 0;
  int peak_holders = 0;
  int peak_waiting = 0;

  shared_exclusive_lock_queue u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_want_exclusive   (in_want_exclusive),
    .in_requester_tag    (in_requester_tag),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_grant_valid     (out_grant_valid),
    .out_grant_tag       (out_grant_tag),
    .out_grant_exclusive (out_grant_exclusive),
    .out_holders         (out_holders),
    .out_waiting         (out_waiting)
  );

  always #CLK_HALF clk = ~clk;

  // grant rule shared by new requests and the queue head
  function automatic logic take_lock(input logic excl);
    logic ok;
    if (holders_now == '0) begin
      ok = 1'b1;
    end else begin
      ok = !held_excl && !excl && (holders_now < selq_pkg::HOLDER_MAX);
    end
    if (ok) begin
      holders_now = holders_now + selq_pkg::HOLDER_W'(1);
      held_excl   = excl;
    end
    return ok;
  endfunction

  task automatic lock_model_step(input logic func, input logic excl,
                                 input logic [selq_pkg::TAG_WIDTH-1:0] tag);
    selq_pkg::result_t            r;
    logic [selq_pkg::ENTRY_W-1:0] head_entry;
    r = '0;
    if (func == FUNC_LOCK) begin
      if (take_lock(excl)) begin
        r.status          = selq_pkg::ST_GRANTED;
        r.grant_valid     = 1'b1;
        r.grant_tag       = tag;
        r.grant_exclusive = excl;
      end else if (wq_fill >= selq_pkg::FILL_FULL) begin
        r.status = selq_pkg::ST_FULL;
      end else begin
        waiters[wq_tail] = {excl, tag};
        wq_tail = (wq_tail == selq_pkg::PTR_LAST) ? '0 : wq_tail + selq_pkg::PTR_W'(1);
        wq_fill = wq_fill + selq_pkg::FILL_W'(1);
        r.status = selq_pkg::ST_QUEUED;
      end
    end else if (holders_now == '0) begin
      r.status = selq_pkg::ST_IGNORED;
    end else begin
      holders_now = holders_now - selq_pkg::HOLDER_W'(1);
      r.status = selq_pkg::ST_UNLOCKED;
      if (wq_fill != '0) begin
        head_entry = waiters[wq_head];
        // head gets exactly one try, stays put on failure
        if (take_lock(head_entry[selq_pkg::TAG_WIDTH])) begin
          r.grant_valid     = 1'b1;
          r.grant_tag       = head_entry[selq_pkg::TAG_WIDTH-1:0];
          r.grant_exclusive = head_entry[selq_pkg::TAG_WIDTH];
          wq_head = (wq_head == selq_pkg::PTR_LAST) ? '0 : wq_head + selq_pkg::PTR_W'(1);
          wq_fill = wq_fill - selq_pkg::FILL_W'(1);
        end
      end
    end
    r.holders = holders_now;
    r.waiting = wq_fill;
    if (int'(holders_now) > peak_holders) peak_holders = int'(holders_now);
    if (int'(wq_fill) > peak_waiting) peak_waiting = int'(wq_fill);
    pending_results.push_back(r);
  endtask

  task automatic send_beat(input logic func, input logic excl,
                           input logic [selq_pkg::TAG_WIDTH-1:0] tag);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid          = 1'b1;
    in_func           = func;
    in_want_exclusive = excl;
    in_requester_tag  = tag;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    lock_model_step(func, excl, tag);
  endtask

  task automatic send_lock(input logic excl, input logic [selq_pkg::TAG_WIDTH-1:0] tag);
    send_beat(FUNC_LOCK, excl, tag);
  endtask

  task automatic send_unlock();
    send_beat(FUNC_UNLOCK, logic'($urandom_range(1)), selq_pkg::TAG_WIDTH'($urandom));
  endtask

  task automatic drain_lock();
    while (holders_now != '0 || wq_fill != '0) send_unlock();
  endtask

  // receiver stall
  always @(negedge clk) begin
    out_stall = rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    selq_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d", out_status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        case (want.status)
          selq_pkg::ST_QUEUED:  queued_seen++;
          selq_pkg::ST_FULL:    refused_seen++;
          selq_pkg::ST_IGNORED: ignored_seen++;
          default: ;
        endcase
        if (want.grant_valid) grants_seen++;
        check_field("status", 16'(want.status), 16'(out_status));
        check_field("grant_valid", 16'(want.grant_valid), 16'(out_grant_valid));
        check_field("grant_tag", 16'(want.grant_tag), 16'(out_grant_tag));
        check_field("grant_exclusive", 16'(want.grant_exclusive),
                    16'(out_grant_exclusive));
        check_field("holders", 16'(want.holders), 16'(out_holders));
        check_field("waiting", 16'(want.waiting), 16'(out_waiting));
      end
    end
  end

  // free unlock, shared sharing, queue bypass, head retry and mode kept when free
  task automatic test_directed_ops();
    send_unlock();
    send_lock(1'b0, 8'h00);
    send_lock(1'b0, 8'hFF);
    send_lock(1'b1, 8'hA5);
    send_lock(1'b0, 8'h5A);
    send_unlock();
    send_unlock();
    send_unlock();
    send_lock(1'b0, 8'h3C);
    send_lock(1'b1, 8'hC3);
    send_unlock();
    send_unlock();
    send_unlock();
    send_unlock();
    send_lock(1'b1, 8'h81);
    send_unlock();
    send_lock(1'b0, 8'h7E);
    send_lock(1'b1, 8'h01);
    drain_lock();
  endtask

  // exclusive holder keeps everyone waiting until the queue refuses
  task automatic test_queue_overflow();
    send_lock(1'b1, selq_pkg::TAG_WIDTH'($urandom));
    repeat (selq_pkg::QUEUE_DEPTH + 3) begin
      send_lock(logic'($urandom_range(1)), selq_pkg::TAG_WIDTH'($urandom));
    end
    drain_lock();
  endtask

  // fill the holder count to its ceiling; further shared requests must wait
  task automatic test_holder_ceiling();
    // start from a free lock so shared requests are granted
    drain_lock();
    while (holders_now < selq_pkg::HOLDER_MAX) send_lock(1'b0, selq_pkg::TAG_WIDTH'($urandom));
    send_lock(1'b0, 8'h11);
    send_lock(1'b1, 8'h22);
    send_lock(1'b0, 8'h33);
    send_unlock();
    send_unlock();
    send_lock(1'b0, 8'h44);
    drain_lock();
  endtask

  // bursts leaning toward locks or unlocks so the queue fills and empties
  task automatic test_random_traffic(input int n_beats);
    int lock_pct;
    int burst_left;
    lock_pct   = 50;
    burst_left = 0;
    repeat (n_beats) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(24, 4);
        lock_pct   = $urandom_range(85, 20);
      end
      burst_left--;
      if ($urandom_range(99) < lock_pct) begin
        send_lock(logic'($urandom_range(99) < 35), selq_pkg::TAG_WIDTH'($urandom));
      end else begin
        send_unlock();
      end
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_func           = FUNC_LOCK;
    in_want_exclusive = 1'b0;
    in_requester_tag  = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 13;
    recv_idle_pct = 52;
    test_directed_ops();
    test_queue_overflow();
    test_random_traffic(250);

    send_idle_pct = 52;
    recv_idle_pct = 13;
    test_holder_ceiling();
    test_random_traffic(250);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_queue_overflow();
    test_random_traffic(250);

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d beats, %0d results checked: %0d grants, %0d queued, %0d refused,",
             beats_sent, results_checked, grants_seen, queued_seen, refused_seen);
    $display("%0d ignored unlocks, peak holders %0d, peak waiting %0d",
             ignored_seen, peak_holders, peak_waiting);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("timeout: %0d results still outstanding", pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
